// ----- rtl/core/sorted_array_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted array priority queue assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sapq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Sizes, codes and payload types shared by the queue modules.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int TAG_WIDTH   = 16;
  localparam int COUNT_WIDTH = 5;
  localparam int STATUS_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 5;

  localparam logic [COUNT_WIDTH-1:0] CAP_RESET = COUNT_WIDTH'(DEPTH);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAPACITY_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LARGEST_FIRST  = 1'b1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                 mode;
    logic [KEY_WIDTH-1:0] item_key;
    logic [TAG_WIDTH-1:0] item_tag;
  } in_item_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    out_key;
    logic [TAG_WIDTH-1:0]    out_tag;
    logic                    out_valid;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  fill_count;
  } out_item_t;

  typedef struct packed {
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   full;
  } dp_status_t;

endpackage

// ----- rtl/core/sapq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue controller
// Tracks the result register and issues one execute command per transfer.
// ----------------------------------------------------------------------------
module sapq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output sapq_pkg::dp_cmd_t cmd
);
  import sapq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready    = (state == S_IDLE) || res_ready;
  assign res_valid   = (state == S_HOLD);
  assign cmd.execute = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.execute) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (cmd.execute) state_next = S_HOLD;
        else if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- rtl/core/sapq_datapath.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue datapath
// Row of compare-and-shift cells, configuration registers and result register.
// ----------------------------------------------------------------------------
module sapq_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [sapq_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [sapq_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  sapq_pkg::in_item_t                     in_item,
  input  sapq_pkg::dp_cmd_t                      cmd,
  output sapq_pkg::out_item_t                    res_item,
  output sapq_pkg::dp_status_t                   status
);
  import sapq_pkg::*;

  logic [KEY_WIDTH-1:0]   keys [DEPTH];
  logic [TAG_WIDTH-1:0]   tags [DEPTH];
  logic [KEY_WIDTH-1:0]   keys_next [DEPTH];
  logic [TAG_WIDTH-1:0]   tags_next [DEPTH];
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] capacity_limit;
  logic                   largest_first;
  logic [COUNT_WIDTH-1:0] cap_eff;
  logic [DEPTH-1:0]       hit;
  logic [DEPTH-1:0]       go;
  logic [DEPTH-1:0]       go_left;
  logic                   full;
  logic                   empty;
  logic                   do_insert;
  logic                   do_remove;
  out_item_t              result;

  assign cap_eff = (capacity_limit > COUNT_WIDTH'(DEPTH)) ? COUNT_WIDTH'(DEPTH)
                                                          : capacity_limit;
  assign full  = (count >= cap_eff);
  assign empty = (count == '0);
  assign do_insert = cmd.execute && (in_item.mode == MODE_INSERT) && !full;
  assign do_remove = cmd.execute && (in_item.mode == MODE_REMOVE) && !empty;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (COUNT_WIDTH'(i) >= count) ||
               (largest_first ? (keys[i] < in_item.item_key)
                              : (keys[i] > in_item.item_key));
    end
  end

  // The insert place is the first cell that matches, and every cell after it shifts.
  always_comb begin
    go[0] = hit[0];
    for (int i = 1; i < DEPTH; i++) begin
      go[i] = go[i-1] || hit[i];
    end
  end

  assign go_left = {go[DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_next[i] = keys[i];
      tags_next[i] = tags[i];
    end
    if (do_insert) begin
      if (go[0]) begin
        keys_next[0] = in_item.item_key;
        tags_next[0] = in_item.item_tag;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (go_left[i]) begin
          keys_next[i] = keys[i-1];
          tags_next[i] = tags[i-1];
        end else if (go[i]) begin
          keys_next[i] = in_item.item_key;
          tags_next[i] = in_item.item_tag;
        end
      end
    end else if (do_remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        keys_next[i] = keys[i+1];
        tags_next[i] = tags[i+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_insert) count_next = count + 1'b1;
    else if (do_remove) count_next = count - 1'b1;
  end

  always_comb begin
    result.out_key    = '0;
    result.out_tag    = '0;
    result.out_valid  = 1'b0;
    result.status     = STATUS_OK;
    result.fill_count = count_next;
    if (in_item.mode == MODE_REMOVE) begin
      if (empty) begin
        result.status = STATUS_EMPTY;
      end else begin
        result.out_key   = keys[0];
        result.out_tag   = tags[0];
        result.out_valid = 1'b1;
      end
    end else if (full) begin
      result.status = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      keys[i] <= keys_next[i];
      tags[i] <= tags_next[i];
    end
    if (cmd.execute) res_item <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      capacity_limit <= CAP_RESET;
      largest_first  <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAPACITY_LIMIT: capacity_limit <= cfg_data;
          REG_LARGEST_FIRST:  largest_first  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign status.count = count;
  assign status.full  = full;

endmodule

// ----- rtl/core/sorted_array_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Bounded queue of key and tag entries kept in removal order.
// ----------------------------------------------------------------------------
// In each insert or remove, a row of sixteen compare-and-shift cells finds
// the insert place and moves every entry that must move in a single step,
// and the result register takes the outcome at the same edge as the cells.
// A new item is taken in every cycle in which the result register is empty or
// its result is being taken, so the sustained rate is one item per cycle.
// Entries of equal key leave in arrival order, and the configuration port
// is always ready.
module sorted_array_priority_queue (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sapq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sapq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sapq_pkg::in_item_t                   in_item,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output sapq_pkg::out_item_t                  res_item
);
  import sapq_pkg::*;
  `include "sorted_array_priority_queue_defines.svh"

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd)
  );

  sapq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .res_item  (res_item),
    .status    (dp_status)
  );

  `SAPQ_ASSERT_SAME(a_count_bound, 1'b1, dp_status.count <= COUNT_WIDTH'(DEPTH), "fill above depth")
  `SAPQ_ASSERT_NEXT(a_empty_remove, in_valid && in_ready && in_item.mode == MODE_REMOVE && dp_status.count == '0, res_valid && res_item.status == STATUS_EMPTY && !res_item.out_valid, "empty remove result wrong")
  `SAPQ_ASSERT_NEXT(a_insert_grows, in_valid && in_ready && in_item.mode == MODE_INSERT && !dp_status.full, dp_status.count == $past(dp_status.count) + 1'b1, "insert did not grow fill")
  `SAPQ_ASSERT_NEXT(a_full_drop, in_valid && in_ready && in_item.mode == MODE_INSERT && dp_status.full, res_item.status == STATUS_FULL && $stable(dp_status.count), "full insert not dropped")

endmodule
